FILE: rtl/jspg_pkg.sv
// Package for the JSON structure prescan guard.
// Holds the payload structs, verdict codes, register indexes and fixed field widths.
// No dependencies.
package jspg_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned BodyLenW  = 26;
  localparam int unsigned BudgetW   = 24;
  localparam int unsigned DepthW    = 10;
  localparam int unsigned CfgDataW  = 26;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned DeepW     = 16;
  localparam int unsigned TokenW    = 25;
  localparam int unsigned ByteCntW  = 27;

  localparam logic [BodyLenW-1:0] MaxBodyLenRst = 26'd8388608;
  localparam logic [BudgetW-1:0]  TokenBudgetRst = 24'd1048576;
  localparam logic [DepthW-1:0]   DepthLimitRst  = 10'd64;

  // Byte counter saturates at 2^26, token counter at all ones.
  localparam logic [ByteCntW-1:0] ByteSat  = 27'd67108864;
  localparam logic [TokenW-1:0]   TokenSat = '1;

  localparam logic [ByteW-1:0] ChQuote     = 8'h22;
  localparam logic [ByteW-1:0] ChBackslash = 8'h5C;
  localparam logic [ByteW-1:0] ChLBracket  = 8'h5B;
  localparam logic [ByteW-1:0] ChRBracket  = 8'h5D;
  localparam logic [ByteW-1:0] ChLBrace    = 8'h7B;
  localparam logic [ByteW-1:0] ChRBrace    = 8'h7D;
  localparam logic [ByteW-1:0] ChComma     = 8'h2C;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_BODY_LEN = 2'd0,
    CFG_TOKEN_LIMIT  = 2'd1,
    CFG_DEPTH_LIMIT  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    VERDICT_PASS      = 2'd0,
    VERDICT_TOO_LARGE = 2'd1,
    VERDICT_OVER_BUDGET = 2'd2,
    VERDICT_TOO_DEEP  = 2'd3
  } verdict_e;

  typedef struct packed {
    logic [ByteW-1:0] body_byte;
    logic             last_byte;
  } in_item_t;

  typedef struct packed {
    verdict_e              verdict;
    logic [DeepW-1:0]      deepest_seen;
    logic [TokenW-1:0]     token_total;
    logic [ByteCntW-1:0]   byte_total;
  } out_item_t;

endpackage

FILE: rtl/json_structure_prescan_guard.sv
// Top level of the JSON structure prescan guard.
// Depends on jspg_pkg for payload structs, verdict codes and register indexes.
//
// Usage: body bytes enter on the in channel (valid/ready), one per transfer,
// with last_byte set on the final byte of each body. Every byte updates the
// string/escape state, the nesting level and peak, and the structural token
// count in the same cycle it is transferred. Only the last byte of a body
// produces a result on the out channel: the verdict with the deepest level,
// token count and byte count; the scan state then clears for the next body.
// The result is registered and is valid in the cycle after the last byte's transfer.
// Throughput: one byte per cycle while in_ready_o is high, set by the state update.
// The result sits in an output register; while it waits, the input stays
// ready as long as the receiver takes it in the same cycle, so a stalled
// receiver holds off new bytes only while a result is pending.
// Reset clears the scan state and the output valid, and loads the register
// defaults: body length limit 8388608, token limit 1048576, depth limit 64.
// The configuration port writes a register at any edge with cfg_we_i high;
// writes to an unused index are dropped.
module json_structure_prescan_guard #(
  parameter int unsigned LEVEL_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  jspg_pkg::in_item_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output jspg_pkg::out_item_t                out_data_o,
  input  logic                               cfg_we_i,
  input  logic [jspg_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [jspg_pkg::CfgDataW-1:0]      cfg_data_i
);

  localparam logic [LEVEL_BITS-1:0] LevelMax = '1;
  localparam int unsigned CmpW = (LEVEL_BITS > jspg_pkg::DeepW) ? LEVEL_BITS : jspg_pkg::DeepW;

  logic [jspg_pkg::BodyLenW-1:0] max_body_q;
  logic [jspg_pkg::BudgetW-1:0]  budget_q;
  logic [jspg_pkg::DepthW-1:0]   depth_lim_q;

  logic                           in_str_q, in_str_d;
  logic                           esc_q, esc_d;
  logic [LEVEL_BITS-1:0]          level_q, level_d;
  logic [LEVEL_BITS-1:0]          peak_q, peak_d;
  logic [jspg_pkg::TokenW-1:0]    tokens_q, tokens_d;
  logic                           over_q, over_d;
  logic [jspg_pkg::ByteCntW-1:0]  bytes_q, bytes_d;

  logic                           out_valid_q;
  jspg_pkg::out_item_t            out_data_q, out_data_d;

  logic                           in_xfer;
  logic                           is_open, is_close, is_comma;
  logic [CmpW-1:0]                peak_ext;
  jspg_pkg::verdict_e             verdict;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_body_q  <= jspg_pkg::MaxBodyLenRst;
      budget_q    <= jspg_pkg::TokenBudgetRst;
      depth_lim_q <= jspg_pkg::DepthLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        jspg_pkg::CFG_MAX_BODY_LEN: max_body_q  <= cfg_data_i[jspg_pkg::BodyLenW-1:0];
        jspg_pkg::CFG_TOKEN_LIMIT:  budget_q    <= cfg_data_i[jspg_pkg::BudgetW-1:0];
        jspg_pkg::CFG_DEPTH_LIMIT:  depth_lim_q <= cfg_data_i[jspg_pkg::DepthW-1:0];
        default: ;
      endcase
    end
  end

  assign is_open  = (in_data_i.body_byte == jspg_pkg::ChLBracket) ||
                    (in_data_i.body_byte == jspg_pkg::ChLBrace);
  assign is_close = (in_data_i.body_byte == jspg_pkg::ChRBracket) ||
                    (in_data_i.body_byte == jspg_pkg::ChRBrace);
  assign is_comma = (in_data_i.body_byte == jspg_pkg::ChComma);

  // Scan update for one byte.
  always_comb begin
    in_str_d = in_str_q;
    esc_d    = esc_q;
    level_d  = level_q;
    peak_d   = peak_q;
    tokens_d = tokens_q;
    over_d   = over_q;
    bytes_d  = (bytes_q < jspg_pkg::ByteSat) ? bytes_q + 1'b1 : bytes_q;

    if (!over_q) begin
      if (in_str_q) begin
        if (esc_q) begin
          esc_d = 1'b0;
        end else if (in_data_i.body_byte == jspg_pkg::ChBackslash) begin
          esc_d = 1'b1;
        end else if (in_data_i.body_byte == jspg_pkg::ChQuote) begin
          in_str_d = 1'b0;
        end
      end else begin
        if (in_data_i.body_byte == jspg_pkg::ChQuote) begin
          in_str_d = 1'b1;
        end else if (is_open) begin
          if (level_q != LevelMax) begin
            level_d = level_q + 1'b1;
          end
          if (level_d > peak_q) begin
            peak_d = level_d;
          end
        end else if (is_close) begin
          if (level_q != '0) begin
            level_d = level_q - 1'b1;
          end
        end
        if ((is_open || is_close || is_comma) && (tokens_q != jspg_pkg::TokenSat)) begin
          tokens_d = tokens_q + 1'b1;
        end
        // The budget check runs on every byte scanned outside a string.
        if (tokens_d > jspg_pkg::TokenW'(budget_q)) begin
          over_d = 1'b1;
        end
      end
    end
  end

  assign peak_ext = CmpW'(peak_d);

  always_comb begin
    if (bytes_d > jspg_pkg::ByteCntW'(max_body_q)) begin
      verdict = jspg_pkg::VERDICT_TOO_LARGE;
    end else if (over_d) begin
      verdict = jspg_pkg::VERDICT_OVER_BUDGET;
    end else if (peak_ext > CmpW'(depth_lim_q)) begin
      verdict = jspg_pkg::VERDICT_TOO_DEEP;
    end else begin
      verdict = jspg_pkg::VERDICT_PASS;
    end
    out_data_d.verdict      = verdict;
    out_data_d.deepest_seen = (peak_ext > CmpW'({jspg_pkg::DeepW{1'b1}})) ?
                              {jspg_pkg::DeepW{1'b1}} : peak_ext[jspg_pkg::DeepW-1:0];
    out_data_d.token_total  = tokens_d;
    out_data_d.byte_total   = bytes_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_str_q <= 1'b0;
      esc_q    <= 1'b0;
      level_q  <= '0;
      peak_q   <= '0;
      tokens_q <= '0;
      over_q   <= 1'b0;
      bytes_q  <= '0;
    end else if (in_xfer) begin
      if (in_data_i.last_byte) begin
        in_str_q <= 1'b0;
        esc_q    <= 1'b0;
        level_q  <= '0;
        peak_q   <= '0;
        tokens_q <= '0;
        over_q   <= 1'b0;
        bytes_q  <= '0;
      end else begin
        in_str_q <= in_str_d;
        esc_q    <= esc_d;
        level_q  <= level_d;
        peak_q   <= peak_d;
        tokens_q <= tokens_d;
        over_q   <= over_d;
        bytes_q  <= bytes_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer && in_data_i.last_byte) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && in_data_i.last_byte) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: rtl/jspg_checker.sv
// Port-level checks for the JSON structure prescan guard, bound to its top level.
// Depends on jspg_pkg for the payload structs and verdict codes.
module jspg_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input jspg_pkg::in_item_t            in_data_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input jspg_pkg::out_item_t           out_data_o
);

  // A pending result holds its value until it is transferred.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result changed or dropped while stalled");

  // Every last byte yields a result in the next cycle.
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.last_byte) |=> out_valid_o)
    else $error("no result after the last byte of a body");

  // A new result appears only after a last byte.
  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && in_data_i.last_byte))
    else $error("result without a last byte");

  // A body holds at least one byte, and a budget verdict at least one token.
  a_figures_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.byte_total != '0) &&
                     ((out_data_o.verdict != jspg_pkg::VERDICT_OVER_BUDGET) ||
                      (out_data_o.token_total != '0))))
    else $error("result figures inconsistent");

endmodule

bind json_structure_prescan_guard jspg_checker u_jspg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

FILE: verif/tb_json_structure_prescan_guard.sv
`timescale 1ns / 100ps
// Testbench for json_structure_prescan_guard: streams request bodies through the
// byte channel and checks every verdict against a behavioral scanner kept here.
// Depends on jspg_pkg and the RTL top level; needs no other files.
module tb_json_structure_prescan_guard;

  localparam int unsigned LevelBits = 16;
  localparam logic [jspg_pkg::CfgIdxW-1:0] CfgIdxUnused = 2'd3;
  localparam int unsigned RandomItems = 1550;
  localparam int unsigned NumPhases = 8;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  jspg_pkg::in_item_t            in_data = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  jspg_pkg::out_item_t           out_data;
  logic                          cfg_we = 1'b0;
  logic [jspg_pkg::CfgIdxW-1:0]  cfg_idx = '0;
  logic [jspg_pkg::CfgDataW-1:0] cfg_data = '0;

  // Sender and receiver pacing, changed between phases.
  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  bit          sender_hold = 1'b0;

  jspg_pkg::in_item_t  pending_bytes[$];
  logic [7:0]          body_buf[$];
  jspg_pkg::out_item_t expected_verdicts[$];
  int unsigned queued_count = 0;
  int unsigned fail_count = 0;

  // Register copies and scan state of the behavioral scanner.
  logic [jspg_pkg::BodyLenW-1:0] lim_body = jspg_pkg::MaxBodyLenRst;
  logic [jspg_pkg::BudgetW-1:0]  lim_tokens = jspg_pkg::TokenBudgetRst;
  logic [jspg_pkg::DepthW-1:0]   lim_depth = jspg_pkg::DepthLimitRst;
  bit                            in_str = 1'b0;
  bit                            esc_next = 1'b0;
  bit                            frozen = 1'b0;
  logic [LevelBits-1:0]          nest_lvl = '0;
  logic [LevelBits-1:0]          nest_max = '0;
  logic [jspg_pkg::TokenW-1:0]   tok_cnt = '0;
  logic [jspg_pkg::ByteCntW-1:0] byte_cnt = '0;

  json_structure_prescan_guard u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // Advances the scanner by one accepted byte and queues a verdict on a last byte.
  function automatic void prescan_step(jspg_pkg::in_item_t item);
    jspg_pkg::out_item_t res;
    bit                  is_tok;
    is_tok = 1'b0;
    if (byte_cnt < jspg_pkg::ByteSat) byte_cnt++;
    if (!frozen) begin
      if (in_str) begin
        if (esc_next) esc_next = 1'b0;
        else if (item.body_byte == jspg_pkg::ChBackslash) esc_next = 1'b1;
        else if (item.body_byte == jspg_pkg::ChQuote) in_str = 1'b0;
      end else begin
        case (item.body_byte)
          jspg_pkg::ChQuote: in_str = 1'b1;
          jspg_pkg::ChLBracket, jspg_pkg::ChLBrace: begin
            if (nest_lvl != '1) nest_lvl++;
            if (nest_lvl > nest_max) nest_max = nest_lvl;
            is_tok = 1'b1;
          end
          jspg_pkg::ChRBracket, jspg_pkg::ChRBrace: begin
            if (nest_lvl != '0) nest_lvl--;
            is_tok = 1'b1;
          end
          jspg_pkg::ChComma: is_tok = 1'b1;
          default: ;
        endcase
        if (is_tok && tok_cnt != jspg_pkg::TokenSat) tok_cnt++;
        // The budget is only checked for bytes seen outside a string.
        if (tok_cnt > lim_tokens) frozen = 1'b1;
      end
    end
    if (item.last_byte) begin
      if (byte_cnt > lim_body) res.verdict = jspg_pkg::VERDICT_TOO_LARGE;
      else if (frozen) res.verdict = jspg_pkg::VERDICT_OVER_BUDGET;
      else if (nest_max > lim_depth) res.verdict = jspg_pkg::VERDICT_TOO_DEEP;
      else res.verdict = jspg_pkg::VERDICT_PASS;
      res.deepest_seen = nest_max;
      res.token_total = tok_cnt;
      res.byte_total = byte_cnt;
      expected_verdicts.push_back(res);
      in_str = 1'b0;
      esc_next = 1'b0;
      frozen = 1'b0;
      nest_lvl = '0;
      nest_max = '0;
      tok_cnt = '0;
      byte_cnt = '0;
    end
  endfunction

  // Byte driver: a new transfer is offered only once the previous one completed.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_bytes.size() != 0 && !sender_hold && $urandom_range(99) >= in_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin
    jspg_pkg::out_item_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("unexpected result, verdict", out_data.verdict, 0);
        end else begin
          want = expected_verdicts.pop_front();
          if (out_data.verdict !== want.verdict)
            report_mismatch("verdict", out_data.verdict, want.verdict);
          if (out_data.deepest_seen !== want.deepest_seen)
            report_mismatch("deepest_seen", out_data.deepest_seen, want.deepest_seen);
          if (out_data.token_total !== want.token_total)
            report_mismatch("token_total", out_data.token_total, want.token_total);
          if (out_data.byte_total !== want.byte_total)
            report_mismatch("byte_total", out_data.byte_total, want.byte_total);
        end
      end
      if (in_valid && in_ready) prescan_step(in_data);
    end
  end

  task automatic write_reg(logic [jspg_pkg::CfgIdxW-1:0] idx,
                           logic [jspg_pkg::CfgDataW-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    case (idx)
      jspg_pkg::CFG_MAX_BODY_LEN: lim_body = data[jspg_pkg::BodyLenW-1:0];
      jspg_pkg::CFG_TOKEN_LIMIT:  lim_tokens = data[jspg_pkg::BudgetW-1:0];
      jspg_pkg::CFG_DEPTH_LIMIT:  lim_depth = data[jspg_pkg::DepthW-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_limits(logic [jspg_pkg::CfgDataW-1:0] body,
                              logic [jspg_pkg::CfgDataW-1:0] budget,
                              logic [jspg_pkg::CfgDataW-1:0] depth);
    write_reg(jspg_pkg::CFG_MAX_BODY_LEN, body);
    write_reg(jspg_pkg::CFG_TOKEN_LIMIT, budget);
    write_reg(jspg_pkg::CFG_DEPTH_LIMIT, depth);
  endtask

  // Waits until every byte is transferred and every verdict has come back.
  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_valid || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic void close_body();
    jspg_pkg::in_item_t item;
    foreach (body_buf[i]) begin
      item.body_byte = body_buf[i];
      item.last_byte = (i == body_buf.size() - 1);
      pending_bytes.push_back(item);
    end
    queued_count += body_buf.size();
    body_buf.delete();
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) body_buf.push_back(s[i]);
    close_body();
  endfunction

  // Mostly nested containers with strings and commas; closes what it opened.
  function automatic void add_structured_body(int unsigned steps);
    int unsigned depth;
    int unsigned len;
    depth = 0;
    repeat (steps) begin
      case ($urandom_range(5))
        0, 1: begin
          body_buf.push_back($urandom_range(1) ? jspg_pkg::ChLBracket : jspg_pkg::ChLBrace);
          depth++;
        end
        2: if (depth != 0) begin
          body_buf.push_back($urandom_range(1) ? jspg_pkg::ChRBracket : jspg_pkg::ChRBrace);
          depth--;
        end
        3: begin
          len = $urandom_range(4);
          body_buf.push_back(jspg_pkg::ChQuote);
          repeat (len) begin
            // An escape may hide a quote, a bracket or any other byte.
            if ($urandom_range(3) == 0) begin
              body_buf.push_back(jspg_pkg::ChBackslash);
              body_buf.push_back(8'($urandom_range(255)));
            end else begin
              body_buf.push_back(8'($urandom_range(122, 97)));
            end
          end
          body_buf.push_back(jspg_pkg::ChQuote);
        end
        4: body_buf.push_back(jspg_pkg::ChComma);
        default: body_buf.push_back(8'($urandom_range(255)));
      endcase
    end
    repeat (depth)
      body_buf.push_back($urandom_range(1) ? jspg_pkg::ChRBracket : jspg_pkg::ChRBrace);
    if (body_buf.size() == 0) body_buf.push_back(jspg_pkg::ChComma);
    close_body();
  endfunction

  function automatic void add_noise_body(int unsigned len);
    repeat (len) body_buf.push_back(8'($urandom_range(255)));
    close_body();
  endfunction

  initial begin
    int unsigned in_idle_set[4];
    int unsigned out_stall_set[4];
    int unsigned per_phase;
    int unsigned phase_start;
    in_idle_set = '{0, 60, 0, 20};
    out_stall_set = '{0, 0, 60, 20};
    per_phase = RandomItems / NumPhases;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed bodies under the reset limits.
    push_text("[");
    push_text("]");
    body_buf.push_back(8'h00);
    close_body();
    body_buf.push_back(8'hFF);
    close_body();
    push_text("[\"\\\"\",{}]");
    push_text("}],\"");
    wait_idle();

    // Tight limits make each verdict code appear in turn.
    apply_limits(26'd3, 26'd1, 26'd0);
    push_text("[]");
    push_text("[a");
    push_text("ab,");
    push_text("abcd");
    wait_idle();

    for (int p = 0; p < NumPhases; p++) begin
      wait_idle();
      in_idle_pct <= in_idle_set[p % 4];
      out_stall_pct <= out_stall_set[p % 4];
      case (p)
        0: apply_limits('1, '1, '1);
        1: apply_limits('0, '0, '0);
        4: apply_limits(jspg_pkg::CfgDataW'($urandom), jspg_pkg::CfgDataW'($urandom),
                        jspg_pkg::CfgDataW'($urandom));
        6: begin
          apply_limits(26'h2AAAAAA, 26'h1555555, 26'h2AA);
          write_reg(CfgIdxUnused, jspg_pkg::CfgDataW'($urandom));
        end
        default: apply_limits(jspg_pkg::CfgDataW'($urandom_range(30, 4)),
                              jspg_pkg::CfgDataW'($urandom_range(12, 1)),
                              jspg_pkg::CfgDataW'($urandom_range(4, 1)));
      endcase
      phase_start = queued_count;
      while (queued_count - phase_start < per_phase) begin
        if ($urandom_range(3) != 0) add_structured_body($urandom_range(10, 1));
        else add_noise_body($urandom_range(12, 1));
      end
      if (p == 3) begin
        while (pending_bytes.size() > per_phase / 2) @(posedge clk);
        sender_hold <= 1'b1;
        @(posedge clk);
        while (in_valid || expected_verdicts.size() != 0) @(posedge clk);
        sender_hold <= 1'b0;
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && expected_verdicts.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/jspg_pkg.sv
rtl/json_structure_prescan_guard.sv
rtl/jspg_checker.sv
verif/tb_json_structure_prescan_guard.sv
